// ===== rtl/core/velocity_deadband_cost_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the velocity deadband cost unit
// Concurrent property shorthands; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_DEADBAND_COST_UNIT_ASSERT_SVH
`define VELOCITY_DEADBAND_COST_UNIT_ASSERT_SVH

// same-cycle implication
`define VDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vdc_pkg.sv =====
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types and constants of the velocity deadband cost unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vdc_pkg;

	localparam int VEL_W      = 16;
	localparam int DB_W       = 15;
	localparam int SUM_W      = 24;
	localparam int COST_W     = 32;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED,
		CFG_HOLONOMIC,
		CFG_EXPONENT,
		CFG_WEIGHT,
		CFG_DEADBAND_X,
		CFG_DEADBAND_Y,
		CFG_DEADBAND_YAW,
		CFG_TIME_STEP
	} cfg_idx_t;

	typedef struct packed {
		logic            enabled;
		logic            holonomic;
		logic [3:0]      exponent;
		logic [15:0]     weight;
		logic [DB_W-1:0] deadband_x;
		logic [DB_W-1:0] deadband_y;
		logic [DB_W-1:0] deadband_yaw;
		logic [15:0]     time_step;
	} cfg_t;

	// one finished trajectory handed from front to back
	typedef struct packed {
		logic              en;
		logic [SUM_W-1:0]  sum;
		logic [COST_W-1:0] prior;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PROD,
		B_WLO,
		B_WHI,
		B_BASE,
		B_POW,
		B_SAT,
		B_ADD
	} back_state_t;

endpackage

// ===== rtl/core/vdc_fifo.sv =====
// ----------------------------------------------------------------------------
// vdc_fifo
// Small first-word-fall-through queue of register slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/vdc_front.sv =====
// ----------------------------------------------------------------------------
// vdc_front
// Takes timesteps, accumulates deadband penalties, queues finished rollouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdc_front import vdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              push,
	output logic              full,
	input  logic [VEL_W-1:0]  vel_x,
	input  logic [VEL_W-1:0]  vel_y,
	input  logic [VEL_W-1:0]  yaw_rate,
	input  logic              last_step,
	input  logic [COST_W-1:0] prior_cost,
	input  logic              job_full,
	output logic              job_push,
	output job_t              job
);

	// max(db - |v|, 0); |v| kept exact on 17 bits
	function automatic logic [DB_W-1:0] db_term(input logic [DB_W-1:0] db,
	                                             input logic [VEL_W-1:0] v);
		logic [VEL_W:0] ext;
		logic [VEL_W:0] mag;
		logic [VEL_W:0] dbe;
		logic [VEL_W:0] diff;
		ext  = {v[VEL_W-1], v};
		mag  = v[VEL_W-1] ? ((VEL_W+1)'(0) - ext) : ext;
		dbe  = {2'b00, db};
		diff = dbe - mag;
		db_term = (dbe > mag) ? diff[DB_W-1:0] : '0;
	endfunction

	logic [SUM_W-1:0] sum_q;
	logic [DB_W+1:0]  add;
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic [SUM_W-1:0] sum_next;
	logic             accept;

	assign full   = job_full;
	assign accept = push & ~job_full;

	always_comb begin
		add = {2'b00, db_term(cfg.deadband_x, vel_x)}
		    + {2'b00, db_term(cfg.deadband_yaw, yaw_rate)}
		    + (cfg.holonomic ? {2'b00, db_term(cfg.deadband_y, vel_y)} : '0);
		sum_ext  = {1'b0, sum_q} + {{(SUM_W-DB_W-1){1'b0}}, add};
		sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		sum_next = cfg.enabled ? sum_sat : sum_q;
	end

	assign job_push  = accept & last_step;
	assign job.en    = cfg.enabled;
	assign job.sum   = sum_next;
	assign job.prior = prior_cost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= last_step ? '0 : sum_next;
		end
	end

endmodule

// ===== rtl/core/vdc_back.sv =====
// ----------------------------------------------------------------------------
// vdc_back
// Scales a finished penalty sum, applies the power, adds the prior cost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vdc_back import vdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              job_empty,
	input  job_t              job,
	output logic              job_pop,
	input  logic              res_full,
	output logic              res_push,
	output logic [COST_W-1:0] res_cost
);

	back_state_t       state_q, state_d;
	logic [SUM_W-1:0]  sum_q;
	logic [COST_W-1:0] prior_q;
	logic              en_q;
	logic [39:0]       prod_q;
	logic [35:0]       lo_q, hi_q;
	logic [COST_W-1:0] base_q, acc_q;
	logic [63:0]       mul_q;
	logic [3:0]        cnt_q;
	logic [3:0]        cnt_inc;
	logic [36:0]       base_full;
	logic [COST_W-1:0] base_sat;
	logic [47:0]       mul_sh;
	logic [COST_W-1:0] pow_sat;
	logic [COST_W:0]   total;

	assign cnt_inc = cnt_q + 4'd1;

	always_comb begin
		// (prod * w) >> 20 split as hi*w + ((lo*w) >> 20)
		base_full = {1'b0, hi_q} + {21'd0, lo_q[35:20]};
		base_sat  = (base_full[36:32] != '0) ? '1 : base_full[31:0];
		mul_sh    = mul_q[63:16];
		pow_sat   = (mul_sh[47:32] != '0) ? '1 : mul_sh[31:0];
		total     = {1'b0, prior_q} + {1'b0, acc_q};
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		res_cost = en_q ? (total[COST_W] ? '1 : total[COST_W-1:0]) : prior_q;
		case (state_q)
			B_IDLE: begin
				if (!job_empty && !res_full) begin
					job_pop = 1'b1;
					state_d = job.en ? B_PROD : B_ADD;
				end
			end
			B_PROD: state_d = B_WLO;
			B_WLO:  state_d = B_WHI;
			B_WHI:  state_d = B_BASE;
			B_BASE: state_d = (cfg.exponent > 4'd1) ? B_POW : B_ADD;
			B_POW:  state_d = B_SAT;
			B_SAT:  state_d = (cnt_inc < cfg.exponent) ? B_POW : B_ADD;
			B_ADD: begin
				res_push = 1'b1;
				state_d  = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_pop) begin
					sum_q   <= job.sum;
					prior_q <= job.prior;
					en_q    <= job.en;
				end
			end
			B_PROD: prod_q <= sum_q * cfg.time_step;
			B_WLO:  lo_q   <= prod_q[19:0] * cfg.weight;
			B_WHI:  hi_q   <= prod_q[39:20] * cfg.weight;
			B_BASE: begin
				base_q <= base_sat;
				acc_q  <= base_sat;
				cnt_q  <= 4'd1;
			end
			B_POW:  mul_q  <= acc_q * base_q;
			B_SAT: begin
				acc_q <= pow_sat;
				cnt_q <= cnt_inc;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/velocity_deadband_cost_unit.sv =====
// ----------------------------------------------------------------------------
// velocity_deadband_cost_unit
// Velocity deadband critic: per-rollout deadband penalty cost, Q16.16 output.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive one timestep word (vel_x, vel_y, yaw_rate,
//   last_step, prior_cost) with push; it is taken on an edge with full low.
//   A timestep word is taken every cycle while full is low; full rises only when the job
//   queue between the front and the back is packed with finished rollouts.
//   Result side is a queue too: total_cost is valid while empty is low and
//   is taken on an edge with pop high. Only a last_step word makes a result.
//   The back sequencer finishes one rollout before it pops the next: a
//   24x16 product, two 20x16 weight halves, then one 32x32 multiply and
//   one saturate step per power iteration. A disabled rollout skips to
//   the final add, and at power 0 or 1 no power iteration runs.
//   A stalled receiver just parks results in the result queue; the back
//   waits for a free slot, then the job queue fills and full rises.
//   Reset (arst_n low) clears the accumulator and both queues and loads
//   the register defaults. Write config (cfg_we/cfg_index/cfg_data) only
//   while no rollout is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module velocity_deadband_cost_unit import vdc_pkg::*; #(
	parameter int QUEUE_DEPTH  = 2,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// timestep input queue
	input  logic                  push,
	output logic                  full,
	input  logic [VEL_W-1:0]      vel_x,
	input  logic [VEL_W-1:0]      vel_y,
	input  logic [VEL_W-1:0]      yaw_rate,
	input  logic                  last_step,
	input  logic [COST_W-1:0]     prior_cost,
	// result queue
	output logic                  empty,
	input  logic                  pop,
	output logic [COST_W-1:0]     total_cost
);

	localparam int JOB_W = $bits(job_t);

	cfg_t              cfg_q;
	job_t              job_in, job_out;
	logic [JOB_W-1:0]  job_out_bits;
	logic              job_push, job_full, job_pop, job_empty;
	logic              res_push, res_full;
	logic [COST_W-1:0] res_cost;

	// Register file; defaults match the critic's usual tuning.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled      <= 1'b1;
			cfg_q.holonomic    <= 1'b0;
			cfg_q.exponent     <= 4'd1;
			cfg_q.weight       <= 16'd8960;
			cfg_q.deadband_x   <= 15'd205;
			cfg_q.deadband_y   <= 15'd205;
			cfg_q.deadband_yaw <= 15'd205;
			cfg_q.time_step    <= 16'd3277;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLED:      cfg_q.enabled      <= cfg_data[0];
				CFG_HOLONOMIC:    cfg_q.holonomic    <= cfg_data[0];
				CFG_EXPONENT:     cfg_q.exponent     <= cfg_data[3:0];
				CFG_WEIGHT:       cfg_q.weight       <= cfg_data;
				CFG_DEADBAND_X:   cfg_q.deadband_x   <= cfg_data[DB_W-1:0];
				CFG_DEADBAND_Y:   cfg_q.deadband_y   <= cfg_data[DB_W-1:0];
				CFG_DEADBAND_YAW: cfg_q.deadband_yaw <= cfg_data[DB_W-1:0];
				CFG_TIME_STEP:    cfg_q.time_step    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: deadband terms and the running sum, one timestep per cycle while the job queue has room.
	vdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.yaw_rate   (yaw_rate),
		.last_step  (last_step),
		.prior_cost (prior_cost),
		.job_full   (job_full),
		.job_push   (job_push),
		.job        (job_in)
	);

	// Finished rollouts wait here so the front keeps streaming.
	vdc_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_out_bits),
		.empty   (job_empty)
	);

	assign job_out = job_t'(job_out_bits);

	// Back: scaling, power and the final saturating add.
	vdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_cost  (res_cost)
	);

	// Output side skid: results park here while the receiver stalls.
	vdc_fifo #(
		.WIDTH (COST_W),
		.DEPTH (RESULT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_cost),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (total_cost),
		.empty   (empty)
	);

endmodule

// ===== rtl/core/vdc_checker.sv =====
// ----------------------------------------------------------------------------
// vdc_checker
// Port-level checks of the velocity deadband cost unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "velocity_deadband_cost_unit_assert.svh"

module vdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        last_step,
	input logic        empty,
	input logic        pop,
	input logic [31:0] total_cost
);

	// rollouts ended on the input side but not yet popped as results
	logic [15:0] pend_q;
	logic        ends, takes;

	assign ends  = push && !full && last_step;
	assign takes = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (ends && !takes) begin
			pend_q <= pend_q + 16'd1;
		end else if (takes && !ends) begin
			pend_q <= pend_q - 16'd1;
		end
	end

	`VDC_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(total_cost), "result dropped while stalled")
	`VDC_ASSERT_IMP(a_res_owed, !empty, pend_q != 16'd0, "result without a pending rollout")
	`VDC_ASSERT_IMP(a_full_owed, full, pend_q != 16'd0, "full with no rollout in flight")
	`VDC_ASSERT_IMP(a_full_rise, $rose(full), $past(push && last_step), "full rose without a last step")

endmodule

bind velocity_deadband_cost_unit vdc_checker u_vdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.last_step  (last_step),
	.empty      (empty),
	.pop        (pop),
	.total_cost (total_cost)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: velocity deadband cost unit bench
// Streams rollout timestep words into the unit under a series of register
// settings, predicts each trajectory cost in the bench and checks every
// result word in order. Both queue sides idle at random except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import vdc_pkg::*;

	// quiet cycles (nothing taken on either side) before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// settle time after the last result, sized for the back path at power 15
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [VEL_W-1:0]  vx;
		logic [VEL_W-1:0]  vy;
		logic [VEL_W-1:0]  wz;
		logic              last;
		logic [COST_W-1:0] prior;
	} step_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [VEL_W-1:0]      vel_x = '0;
	logic [VEL_W-1:0]      vel_y = '0;
	logic [VEL_W-1:0]      yaw_rate = '0;
	logic                  last_step = 1'b0;
	logic [COST_W-1:0]     prior_cost = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [COST_W-1:0]     total_cost;

	velocity_deadband_cost_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.yaw_rate   (yaw_rate),
		.last_step  (last_step),
		.prior_cost (prior_cost),
		.empty      (empty),
		.pop        (pop),
		.total_cost (total_cost)
	);

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	step_word_t        step_feed[$];   // words waiting to be driven
	logic [COST_W-1:0] cost_due[$];    // predicted costs, oldest first
	step_word_t        cur_word;       // word currently on the input ports
	cfg_t              shadow;         // bench copy of the register file
	logic [SUM_W-1:0]  penalty_acc;    // bench copy of the running penalty sum
	int                words_queued = 0;
	int                words_taken = 0;
	int                fail_count = 0;
	int                feed_gap = 0;
	int                drain_gap = 0;
	int                quiet = 0;
	bit                calm = 1'b0;    // set for the tail: no idling on either side

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Cost predictor
	// ------------------------------------------------------------------------
	function automatic logic [31:0] clip32(logic [63:0] x);
		return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	// max(deadband - |v|, 0); |-32768| is 32768, so the term is then zero
	function automatic logic [31:0] deadband_gap(logic [DB_W-1:0] db, logic [VEL_W-1:0] v);
		logic [31:0] mag;
		mag = v[VEL_W-1] ? (32'h1_0000 - 32'(v)) : 32'(v);
		return (32'(db) > mag) ? (32'(db) - mag) : 32'd0;
	endfunction

	// one accepted timestep: grow the sum, and on the last step predict the cost
	function automatic void predict_cost(step_word_t w);
		logic [31:0] add;
		logic [31:0] grown;
		logic [63:0] prod;
		logic [63:0] base;
		logic [63:0] acc;
		if (shadow.enabled) begin
			add = deadband_gap(shadow.deadband_x, w.vx) + deadband_gap(shadow.deadband_yaw, w.wz);
			if (shadow.holonomic) begin
				add = add + deadband_gap(shadow.deadband_y, w.vy);
			end
			grown = 32'(penalty_acc) + add;
			penalty_acc = (grown > 32'h00FF_FFFF) ? 24'hFF_FFFF : grown[SUM_W-1:0];
		end
		if (w.last) begin
			if (shadow.enabled) begin
				// Q12.12 * Q0.16 * Q8.8 -> Q16.16 by dropping 20 bits
				prod = 64'(penalty_acc) * 64'(shadow.time_step);
				base = 64'(clip32((prod * 64'(shadow.weight)) >> 20));
				acc = base;
				for (int p = 1; p < int'(shadow.exponent); p++) begin
					acc = 64'(clip32((acc * base) >> 16));
				end
				cost_due = {cost_due, clip32(64'(w.prior) + acc)};
			end else begin
				// disabled: prior passes straight through
				cost_due = {cost_due, w.prior};
			end
			penalty_acc = '0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Input driver: one word per push, holds while full, random idle bursts
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic load;
		load = 1'b0;
		if (push && !full) begin
			predict_cost(cur_word);
			words_taken++;
		end
		// ports may change unless a word is being held against full
		if (!(push && full)) begin
			if (feed_gap > 0) begin
				feed_gap--;
			end else if (step_feed.size() > 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					feed_gap = $urandom_range(0, 6);
				end else begin
					cur_word = step_feed.pop_front();
					load = 1'b1;
					vel_x <= cur_word.vx;
					vel_y <= cur_word.vy;
					yaw_rate <= cur_word.wz;
					last_step <= cur_word.last;
					prior_cost <= cur_word.prior;
				end
			end
			push <= load;
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: compare each popped word with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic [COST_W-1:0] want;
		if (pop && !empty) begin
			if (cost_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: result word %h with nothing expected", $realtime, total_cost);
				end
			end else begin
				want = cost_due.pop_front();
				if (total_cost !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: total_cost expected %h actual %h",
							$realtime, want, total_cost);
					end
				end
			end
		end
		// stall bursts on the pop side
		if (drain_gap > 0) begin
			drain_gap--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			drain_gap = $urandom_range(0, 6);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Hang watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= HANG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_word(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz,
		logic last, logic [31:0] prior);
		step_word_t w;
		w.vx = vx;
		w.vy = vy;
		w.wz = wz;
		w.last = last;
		w.prior = prior;
		step_feed.push_back(w);
		words_queued++;
	endtask

	// register write; caller sits just past a rising edge
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ENABLED:      shadow.enabled = val[0];
			CFG_HOLONOMIC:    shadow.holonomic = val[0];
			CFG_EXPONENT:     shadow.exponent = val[3:0];
			CFG_WEIGHT:       shadow.weight = val;
			CFG_DEADBAND_X:   shadow.deadband_x = val[DB_W-1:0];
			CFG_DEADBAND_Y:   shadow.deadband_y = val[DB_W-1:0];
			CFG_DEADBAND_YAW: shadow.deadband_yaw = val[DB_W-1:0];
			CFG_TIME_STEP:    shadow.time_step = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// full register set; unused upper data bits carry junk
	task automatic load_setting(bit en, bit hol, logic [3:0] pw, logic [15:0] wt,
		logic [14:0] dbx, logic [14:0] dby, logic [14:0] dbw, logic [15:0] ts);
		write_reg(CFG_ENABLED, {15'($urandom), en});
		write_reg(CFG_HOLONOMIC, {15'($urandom), hol});
		write_reg(CFG_EXPONENT, {12'($urandom), pw});
		write_reg(CFG_WEIGHT, wt);
		write_reg(CFG_DEADBAND_X, {1'($urandom), dbx});
		write_reg(CFG_DEADBAND_Y, {1'($urandom), dby});
		write_reg(CFG_DEADBAND_YAW, {1'($urandom), dbw});
		write_reg(CFG_TIME_STEP, ts);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every word is in and every result is out, then let the back drain
	task automatic settle();
		while (words_taken != words_queued || cost_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_vel(logic [14:0] db);
		int mag;
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1, 2: begin
				// around the deadband edge
				mag = $urandom_range(0, int'(db) + 64);
				return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
			end
			3: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: begin
				mag = $urandom_range(0, 1023);
				return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_prior();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [14:0] pick_db();
		case ($urandom_range(0, 4))
			0: return 15'd0;
			1: return 15'h7FFF;
			2: return 15'($urandom_range(0, 2047));
			default: return 15'($urandom);
		endcase
	endfunction

	task automatic queue_random_word(bit last);
		queue_word(pick_vel(shadow.deadband_x), pick_vel(shadow.deadband_y),
			pick_vel(shadow.deadband_yaw), last, pick_prior());
	endtask

	// mostly whole rollouts; now and then a burst of random last flags
	task automatic queue_rollouts(int count);
		int made;
		int len;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 6);
				repeat (len) queue_random_word(1'($urandom_range(0, 1)));
			end else begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					queue_random_word(i == len - 1);
				end
			end
			made += len;
		end
		// close any open rollout before the next register change
		queue_random_word(1'b1);
	endtask

	task automatic load_random_setting();
		logic [3:0]  pw;
		logic [15:0] wt;
		logic [15:0] ts;
		pw = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: wt = 16'd0;
			1: wt = 16'hFFFF;
			2: wt = 16'($urandom_range(0, 16383));
			default: wt = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: ts = 16'd0;
			1: ts = 16'hFFFF;
			2: ts = 16'($urandom_range(0, 8191));
			default: ts = 16'($urandom);
		endcase
		load_setting($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), pw, wt,
			pick_db(), pick_db(), pick_db(), ts);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		// register defaults after reset
		shadow.enabled = 1'b1;
		shadow.holonomic = 1'b0;
		shadow.exponent = 4'd1;
		shadow.weight = 16'd8960;
		shadow.deadband_x = 15'd205;
		shadow.deadband_y = 15'd205;
		shadow.deadband_yaw = 15'd205;
		shadow.time_step = 16'd3277;
		penalty_acc = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: zero speed, both extremes, exactly on the deadband, just inside
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000);
		queue_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 32'hFFFF_FFFF);
		queue_word(16'h8000, 16'h8000, 16'h8000, 1'b0, 32'h0000_0000);
		queue_word(16'd205, 16'hFF33, 16'hFF33, 1'b0, 32'h0000_0000);
		queue_word(16'hFFFF, 16'h0001, 16'hFF34, 1'b1, 32'h0000_0000);
		// single-step rollout, prior at the top so the sum saturates
		queue_word(16'h0000, 16'h8000, 16'h0000, 1'b1, 32'hFFFF_FFFF);
		queue_word(16'd100, 16'h7FFF, 16'hFF9C, 1'b1, 32'h1234_5678);
		settle();

		// everything at its maximum: power 15, full scale base saturates
		load_setting(1'b1, 1'b1, 4'd15, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000);
		queue_word(16'h8000, 16'h7FFF, 16'h0001, 1'b1, 32'h0000_0001);
		settle();

		// disabled: prior passes through, sum is cleared on last step
		load_setting(1'b0, 1'b1, 4'd2, 16'd8960, 15'd205, 15'd205, 15'd205, 16'd3277);
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b0, 32'hDEAD_BEEF);
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'hFFFF_FFFF);
		queue_word(16'h0100, 16'h0000, 16'h0000, 1'b1, 32'h0000_1234);
		settle();

		// everything zero, power zero
		load_setting(1'b1, 1'b1, 4'd0, 16'd0, 15'd0, 15'd0, 15'd0, 16'd0);
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0000_0005);
		settle();

		// zero x and yaw deadbands with a live weight
		load_setting(1'b1, 1'b0, 4'd3, 16'h2300, 15'd0, 15'h7FFF, 15'd0, 16'hCCCD);
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0000_0007);
		settle();

		// power beyond 8 on a base near 1.0 and near 0.5
		load_setting(1'b1, 1'b0, 4'd9, 16'h0100, 15'h1000, 15'd0, 15'd0, 16'hFFFF);
		queue_word(16'h0000, 16'h1234, 16'h7FFF, 1'b1, 32'h0000_0000);
		queue_word(16'h0800, 16'h1234, 16'h7FFF, 1'b1, 32'h0001_0000);
		settle();

		// long rollout that builds up a large penalty sum
		load_setting(1'b1, 1'b1, 4'd1, 16'h0100, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'h0100);
		for (int i = 0; i < 199; i++) begin
			queue_word(16'($urandom_range(0, 255)), 16'h8000, 16'h0000, 1'b0, $urandom);
		end
		queue_word(16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0000_0100);
		settle();

		// random settings, random rollouts; the tail runs without idling
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9) begin
				calm = 1'b1;
			end
			load_random_setting();
			queue_rollouts(100);
			settle();
		end

		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
